FILE: rtl/ctcgd_pkg.sv
package ctcgd_pkg;

    localparam int MAX_CLASSES = 8192;
    localparam int POS_W       = $clog2(MAX_CLASSES + 1);
    localparam int CLASS_W     = 13;
    localparam int LOGIT_W     = 16;
    localparam int SCORE_W     = 17;
    localparam int EXPSUM_W    = 30;
    localparam int PSUM_W      = 27;
    localparam int COUNT_W     = 11;
    localparam int CHARSET_W   = 14;
    localparam int SCALE_W     = 5;
    localparam int Q30_W       = 31;
    localparam int PROD_W      = 62;
    localparam int DVD_W       = 34;
    localparam int DVS_W       = 30;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 11'd2047;
    localparam logic [EXPSUM_W-1:0] Q16_ONE       = 30'd65536;
    localparam logic [Q30_W-1:0]    Q30_ONE       = 31'h4000_0000;
    localparam logic [4:0]          TAYLOR_LAST   = 5'd18;
    localparam logic [2:0]          SQUARE_LAST   = 3'd4;
    localparam logic [5:0]          SHIFT_BASE    = 6'd25;

    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 5'b11001;
    localparam logic [CHARSET_W-1:0] CHARSET_RESET = 14'd8192;

    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_SCALE   = 2'd0;
    localparam logic [1:0] REG_CHARSET = 2'd1;
    localparam logic [1:0] REG_SCORE   = 2'd2;

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LATCH    = 5'd1;
    localparam logic [4:0] OP_FIRST    = 5'd2;
    localparam logic [4:0] OP_EXP_INIT = 5'd3;
    localparam logic [4:0] OP_TMUL     = 5'd4;
    localparam logic [4:0] OP_TDIV     = 5'd5;
    localparam logic [4:0] OP_TUPD     = 5'd6;
    localparam logic [4:0] OP_CLAMP    = 5'd7;
    localparam logic [4:0] OP_SMUL     = 5'd8;
    localparam logic [4:0] OP_SRND     = 5'd9;
    localparam logic [4:0] OP_EMUL     = 5'd10;
    localparam logic [4:0] OP_RESCALE  = 5'd11;
    localparam logic [4:0] OP_ADDEXP   = 5'd12;
    localparam logic [4:0] OP_EMIT     = 5'd13;
    localparam logic [4:0] OP_PDIV     = 5'd14;
    localparam logic [4:0] OP_PACC     = 5'd15;
    localparam logic [4:0] OP_ROWFIN   = 5'd16;
    localparam logic [4:0] OP_MDIV     = 5'd17;
    localparam logic [4:0] OP_MEAN     = 5'd18;
    localparam logic [4:0] OP_MZERO    = 5'd19;
    localparam logic [4:0] OP_SCORE    = 5'd20;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic pos_lt_max;
        logic pos_zero;
        logic x_gt_max;
        logic g_over;
        logic i_last;
        logic sq_last;
        logic emit_cond;
        logic score_cond;
        logic mean_cond;
        logic div_done;
        logic out_free;
        logic row_end;
        logic seq_end;
    } status_t;

endpackage

FILE: rtl/ctcgd_if.sv
interface ctcgd_in_if import ctcgd_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [LOGIT_W-1:0] logit;
    logic                      row_end;
    logic                      seq_end;

    modport source (output valid, logit, row_end, seq_end, input ready);
    modport sink (input valid, logit, row_end, seq_end, output ready);
endinterface

interface ctcgd_out_if import ctcgd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] class_idx;
    logic               unknown_class;
    logic               is_score;
    logic [SCORE_W-1:0] score_value;
    logic               last;

    modport source (output valid, class_idx, unknown_class, is_score, score_value, last,
                    input ready);
    modport sink (input valid, class_idx, unknown_class, is_score, score_value, last,
                  output ready);
endinterface

FILE: rtl/ctcgd_div.sv
module ctcgd_div import ctcgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam logic [5:0] STEPS = 6'(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == STEPS - 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("divider restarted while busy");

endmodule

FILE: rtl/ctcgd_datapath.sv
module ctcgd_datapath import ctcgd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic signed [LOGIT_W-1:0] in_logit,
    input  logic                      in_row_end,
    input  logic                      in_seq_end,
    input  logic [SCALE_W-1:0]        scale_exponent,
    input  logic [CHARSET_W-1:0]      charset_limit,
    input  logic                      score_enable,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [CLASS_W-1:0]        out_class_idx,
    output logic                      out_unknown_class,
    output logic                      out_is_score,
    output logic [SCORE_W-1:0]        out_score_value,
    output logic                      out_last
);

    logic signed [LOGIT_W-1:0] x_reg;
    logic                      row_end_reg, seq_end_reg;
    logic signed [LOGIT_W-1:0] max_reg;
    logic [CLASS_W-1:0]        best_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [EXPSUM_W-1:0]       rs_reg;
    logic [CLASS_W-1:0]        prev_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic [PSUM_W-1:0]         psum_reg;
    logic [SCORE_W-1:0]        mean_reg;
    logic [EXPSUM_W-1:0]       g_reg;
    logic [Q30_W-1:0]          term_reg;
    logic signed [Q30_W+1:0]   acc_reg;
    logic [Q30_W-1:0]          r_reg;
    logic [4:0]                i_reg;
    logic [2:0]                sq_reg;
    logic [PROD_W-1:0]         prod_reg;

    logic                      ov_reg;
    logic [CLASS_W-1:0]        o_class_reg;
    logic                      o_unk_reg, o_score_reg, o_last_reg;
    logic [SCORE_W-1:0]        o_val_reg;

    logic signed [LOGIT_W:0]   diff;
    logic [LOGIT_W-1:0]        delta;
    logic [5:0]                shamt;
    logic [63:0]               g_wide;
    logic                      x_gt;
    logic                      out_free;
    logic                      div_start, div_done;
    logic [DVD_W-1:0]          div_dvd, div_q;
    logic [DVS_W-1:0]          div_dvs;
    logic [PROD_W-1:0]         rnd;
    logic [Q30_W-1:0]          q_term;

    assign x_gt     = x_reg > max_reg;
    assign diff     = x_gt ? (LOGIT_W+1)'(x_reg) - (LOGIT_W+1)'(max_reg)
                           : (LOGIT_W+1)'(max_reg) - (LOGIT_W+1)'(x_reg);
    assign delta    = diff[LOGIT_W-1:0];
    assign shamt    = SHIFT_BASE + {{1{scale_exponent[SCALE_W-1]}}, scale_exponent};
    assign g_wide   = {48'd0, delta} << shamt;
    assign out_free = !ov_reg || out_ready;
    assign rnd      = prod_reg + PROD_W'(64'h2000_0000);
    assign q_term   = div_q[Q30_W-1:0];

    always_comb
    begin
        status.pos_lt_max = pos_reg < POS_W'(MAX_CLASSES);
        status.pos_zero   = pos_reg == '0;
        status.x_gt_max   = x_gt;
        status.g_over     = |g_wide[63:EXPSUM_W];
        status.i_last     = i_reg == TAYLOR_LAST;
        status.sq_last    = sq_reg == SQUARE_LAST;
        status.emit_cond  = best_reg != '0 && best_reg != prev_reg;
        status.score_cond = score_enable && cnt_reg < COUNT_MAX && rs_reg != '0;
        status.mean_cond  = score_enable && cnt_reg != '0;
        status.div_done   = div_done;
        status.out_free   = out_free;
        status.row_end    = row_end_reg;
        status.seq_end    = seq_end_reg;
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (cmd.op)
            OP_TDIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod_reg[PROD_W-2:EXPSUM_W]);
                div_dvs   = DVS_W'(i_reg);
            end
            OP_PDIV:
            begin
                div_start = 1'b1;
                div_dvd   = {2'b01, 32'd0} + DVD_W'(rs_reg >> 1);
                div_dvs   = rs_reg;
            end
            OP_MDIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(psum_reg) + DVD_W'(cnt_reg >> 1);
                div_dvs   = DVS_W'(cnt_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ctcgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_end_reg <= 1'b0;
            seq_end_reg <= 1'b0;
            max_reg     <= '0;
            best_reg    <= '0;
            pos_reg     <= '0;
            rs_reg      <= '0;
            prev_reg    <= '0;
            cnt_reg     <= '0;
            psum_reg    <= '0;
            r_reg       <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_EMIT || cmd.op == OP_SCORE)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LATCH:
                begin
                    row_end_reg <= in_row_end;
                    seq_end_reg <= in_seq_end;
                end
                OP_FIRST:
                begin
                    max_reg  <= x_reg;
                    best_reg <= '0;
                    rs_reg   <= Q16_ONE;
                    pos_reg  <= pos_reg + POS_W'(1);
                end
                OP_EXP_INIT:
                begin
                    if (status.g_over)
                    begin
                        r_reg <= '0;
                    end
                end
                OP_CLAMP:
                begin
                    if (acc_reg < 0)
                    begin
                        r_reg <= '0;
                    end
                    else if (acc_reg > (Q30_W+2)'(Q30_ONE))
                    begin
                        r_reg <= Q30_ONE;
                    end
                    else
                    begin
                        r_reg <= acc_reg[Q30_W-1:0];
                    end
                end
                OP_SRND:
                begin
                    r_reg <= rnd[PROD_W-2:EXPSUM_W];
                end
                OP_RESCALE:
                begin
                    rs_reg   <= EXPSUM_W'(rnd[PROD_W-1:EXPSUM_W]) + Q16_ONE;
                    max_reg  <= x_reg;
                    best_reg <= pos_reg[CLASS_W-1:0];
                    pos_reg  <= pos_reg + POS_W'(1);
                end
                OP_ADDEXP:
                begin
                    rs_reg  <= rs_reg + EXPSUM_W'((r_reg + Q30_W'(8192)) >> 14);
                    pos_reg <= pos_reg + POS_W'(1);
                end
                OP_PACC:
                begin
                    psum_reg <= psum_reg + PSUM_W'(div_q[SCORE_W-1:0]);
                    cnt_reg  <= cnt_reg + COUNT_W'(1);
                end
                OP_ROWFIN:
                begin
                    prev_reg <= best_reg;
                    pos_reg  <= '0;
                end
                OP_SCORE:
                begin
                    prev_reg <= '0;
                    cnt_reg  <= '0;
                    psum_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                x_reg <= in_logit;
            end
            OP_EXP_INIT:
            begin
                g_reg    <= g_wide[EXPSUM_W-1:0];
                term_reg <= Q30_ONE;
                acc_reg  <= (Q30_W+2)'(Q30_ONE);
                i_reg    <= 5'd1;
            end
            OP_TMUL:
            begin
                prod_reg <= PROD_W'(term_reg) * PROD_W'(g_reg);
            end
            OP_TUPD:
            begin
                term_reg <= q_term;
                if (i_reg[0])
                begin
                    acc_reg <= acc_reg - (Q30_W+2)'(q_term);
                end
                else
                begin
                    acc_reg <= acc_reg + (Q30_W+2)'(q_term);
                end
                i_reg <= i_reg + 5'd1;
            end
            OP_CLAMP:
            begin
                sq_reg <= '0;
            end
            OP_SMUL:
            begin
                prod_reg <= PROD_W'(r_reg) * PROD_W'(r_reg);
            end
            OP_SRND:
            begin
                sq_reg <= sq_reg + 3'd1;
            end
            OP_EMUL:
            begin
                prod_reg <= PROD_W'(rs_reg) * PROD_W'(r_reg);
            end
            OP_EMIT:
            begin
                o_class_reg <= best_reg;
                o_unk_reg   <= {1'b0, best_reg} >= charset_limit;
                o_score_reg <= 1'b0;
                o_val_reg   <= '0;
                o_last_reg  <= 1'b0;
            end
            OP_MEAN:
            begin
                mean_reg <= div_q[SCORE_W-1:0];
            end
            OP_MZERO:
            begin
                mean_reg <= '0;
            end
            OP_SCORE:
            begin
                o_class_reg <= '0;
                o_unk_reg   <= 1'b0;
                o_score_reg <= 1'b1;
                o_val_reg   <= mean_reg;
                o_last_reg  <= 1'b1;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign out_valid         = ov_reg;
    assign out_class_idx     = o_class_reg;
    assign out_unknown_class = o_unk_reg;
    assign out_is_score      = o_score_reg;
    assign out_score_value   = o_val_reg;
    assign out_last          = o_last_reg;

    a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != '0 |-> rs_reg >= Q16_ONE) else $error("exp sum below one");
    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        r_reg <= Q30_ONE) else $error("exponential above one");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT || cmd.op == OP_SCORE) |-> out_free)
        else $error("result register overwritten");

endmodule

FILE: rtl/ctcgd_ctrl.sv
module ctcgd_ctrl import ctcgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECIDE  = 5'd1;
    localparam logic [4:0] S_TMUL    = 5'd2;
    localparam logic [4:0] S_TDIV    = 5'd3;
    localparam logic [4:0] S_TWAIT   = 5'd4;
    localparam logic [4:0] S_CLAMP   = 5'd5;
    localparam logic [4:0] S_SMUL    = 5'd6;
    localparam logic [4:0] S_SRND    = 5'd7;
    localparam logic [4:0] S_APPLY   = 5'd8;
    localparam logic [4:0] S_RESC    = 5'd9;
    localparam logic [4:0] S_ROW     = 5'd10;
    localparam logic [4:0] S_EMIT_SC = 5'd11;
    localparam logic [4:0] S_PWAIT   = 5'd12;
    localparam logic [4:0] S_ROWFIN  = 5'd13;
    localparam logic [4:0] S_SEQ     = 5'd14;
    localparam logic [4:0] S_MWAIT   = 5'd15;
    localparam logic [4:0] S_SOUT    = 5'd16;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.pos_lt_max)
                begin
                    state_next = S_ROW;
                end
                else if (status.pos_zero)
                begin
                    cmd.op     = OP_FIRST;
                    state_next = S_ROW;
                end
                else
                begin
                    cmd.op     = OP_EXP_INIT;
                    state_next = status.g_over ? S_APPLY : S_TMUL;
                end
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.op     = OP_TDIV;
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_TUPD;
                    state_next = status.i_last ? S_CLAMP : S_TMUL;
                end
            end
            S_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.op     = OP_SMUL;
                state_next = S_SRND;
            end
            S_SRND:
            begin
                cmd.op     = OP_SRND;
                state_next = status.sq_last ? S_APPLY : S_SMUL;
            end
            S_APPLY:
            begin
                if (status.x_gt_max)
                begin
                    cmd.op     = OP_EMUL;
                    state_next = S_RESC;
                end
                else
                begin
                    cmd.op     = OP_ADDEXP;
                    state_next = S_ROW;
                end
            end
            S_RESC:
            begin
                cmd.op     = OP_RESCALE;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                if (!(status.row_end || status.seq_end))
                begin
                    state_next = S_IDLE;
                end
                else if (!status.emit_cond)
                begin
                    state_next = S_ROWFIN;
                end
                else if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_EMIT_SC;
                end
            end
            S_EMIT_SC:
            begin
                if (status.score_cond)
                begin
                    cmd.op     = OP_PDIV;
                    state_next = S_PWAIT;
                end
                else
                begin
                    state_next = S_ROWFIN;
                end
            end
            S_PWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_PACC;
                    state_next = S_ROWFIN;
                end
            end
            S_ROWFIN:
            begin
                cmd.op     = OP_ROWFIN;
                state_next = status.seq_end ? S_SEQ : S_IDLE;
            end
            S_SEQ:
            begin
                if (status.mean_cond)
                begin
                    cmd.op     = OP_MDIV;
                    state_next = S_MWAIT;
                end
                else
                begin
                    cmd.op     = OP_MZERO;
                    state_next = S_SOUT;
                end
            end
            S_MWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_MEAN;
                    state_next = S_SOUT;
                end
            end
            S_SOUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_SCORE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECIDE) else $error("accept lost");
    a_wait_for_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TDIV |=> state_reg == S_TWAIT) else $error("term divide skipped");
    a_score_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SCORE |-> status.seq_end) else $error("score outside sequence end");

endmodule

FILE: rtl/ctc_greedy_decoder_top.sv
// Channel   Direction  Payload
// in_ch     sink       logit, row_end, seq_end
// out_ch    source     class_idx, unknown_class, is_score, score_value, last
// apb       slave      scale_exponent, charset_limit, score_enable
//
// A logit that opens a row or lies past the class limit needs no exponential. One
// whose exponential underflows to zero skips the Taylor terms and the squarings.
// Any other logit runs 18 Taylor terms (multiply, divider start and a divider wait)
// and 5 squarings. A new maximum rescales the sum; any other logit adds to it.
// A row end adds a step, a scored emitted row a divide; a sequence end may add one.
// Reset is asynchronous and active low; output stalls hold the block at row end.
module ctc_greedy_decoder_top import ctcgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ctcgd_in_if.sink              in_ch,
    ctcgd_out_if.source           out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [SCALE_W-1:0]   scale_reg;
    logic [CHARSET_W-1:0] charset_reg;
    logic                 score_en_reg;
    cmd_t                 cmd;
    status_t              status;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RESET;
            charset_reg  <= CHARSET_RESET;
            score_en_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SCALE:   scale_reg    <= pwdata[SCALE_W-1:0];
                REG_CHARSET: charset_reg  <= pwdata[CHARSET_W-1:0];
                REG_SCORE:   score_en_reg <= pwdata[0];
                default:     score_en_reg <= score_en_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCALE:   prdata = 32'(scale_reg);
            REG_CHARSET: prdata = 32'(charset_reg);
            REG_SCORE:   prdata = 32'(score_en_reg);
            default:     prdata = '0;
        endcase
    end

    ctcgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ctcgd_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_logit          (in_ch.logit),
        .in_row_end        (in_ch.row_end),
        .in_seq_end        (in_ch.seq_end),
        .scale_exponent    (scale_reg),
        .charset_limit     (charset_reg),
        .score_enable      (score_en_reg),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .out_class_idx     (out_ch.class_idx),
        .out_unknown_class (out_ch.unknown_class),
        .out_is_score      (out_ch.is_score),
        .out_score_value   (out_ch.score_value),
        .out_last          (out_ch.last)
    );

endmodule

FILE: test/tb.sv
module tb;
    import ctcgd_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd60_000_000;
    localparam int     SETTLE      = 1200;

    typedef struct packed {
        logic [CLASS_W-1:0] class_idx;
        logic               unknown_class;
        logic               is_score;
        logic [SCORE_W-1:0] score_value;
        logic               last;
    } decode_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ctcgd_in_if  in_ch ();
    ctcgd_out_if out_ch ();

    ctc_greedy_decoder_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration and the decoder state.
    int          cfg_scale;
    logic [13:0] cfg_charset;
    logic        cfg_score;

    int          cur_max;
    logic [12:0] cur_best;
    int          cur_pos;
    logic [63:0] cur_exp_sum;
    logic [12:0] prev_class;
    int          emit_count;
    logic [63:0] prob_sum;

    decode_t expected_q[$];
    logic signed [15:0] row_buf[$];

    int     errors;
    int     items_sent;
    int     results_seen;
    int     seqs_sent;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    longint cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_cycles > 0)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("Mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    always @(posedge clk)
    begin
        decode_t got;
        decode_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.class_idx, out_ch.unknown_class, out_ch.is_score,
                    out_ch.score_value, out_ch.last};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report("unexpected result, class", got.class_idx, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.class_idx != want.class_idx)
                    report("class_idx", got.class_idx, want.class_idx);
                if (got.unknown_class != want.unknown_class)
                    report("unknown_class", got.unknown_class, want.unknown_class);
                if (got.is_score != want.is_score)
                    report("is_score", got.is_score, want.is_score);
                if (got.score_value != want.score_value)
                    report("score_value", got.score_value, want.score_value);
                if (got.last != want.last)
                    report("last", got.last, want.last);
            end
        end
    end

    function automatic logic [63:0] exp_neg_q30(input logic [31:0] delta);
        logic [63:0] g;
        logic [63:0] term;
        logic [63:0] r;
        longint      acc;
        int          i;
        g = {32'b0, delta} << (25 + cfg_scale);
        if (g >= 64'h4000_0000)
            return 64'd0;
        acc = 64'h4000_0000;
        term = 64'h4000_0000;
        for (i = 1; i <= 18; i++)
        begin
            term = ((term * g) >> 30) / i;
            if (i % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > 64'h4000_0000)
            acc = 64'h4000_0000;
        r = acc;
        for (i = 0; i < 5; i++)
            r = (r * r + 64'h2000_0000) >> 30;
        return r;
    endfunction

    task automatic decode_logit(input logic signed [15:0] logit, input logic row_end,
                                input logic seq_end);
        int          x;
        logic [63:0] e;
        logic [63:0] p;
        decode_t     res;
        x = logit;
        if (cur_pos < MAX_CLASSES)
        begin
            if (cur_pos == 0)
            begin
                cur_max = x;
                cur_best = '0;
                cur_exp_sum = 64'd65536;
            end
            else if (x > cur_max)
            begin
                e = exp_neg_q30(x - cur_max);
                cur_exp_sum = ((cur_exp_sum * e + 64'h2000_0000) >> 30) + 64'd65536;
                cur_max = x;
                cur_best = 13'(cur_pos);
            end
            else
            begin
                e = exp_neg_q30(cur_max - x);
                cur_exp_sum = cur_exp_sum + ((e + 64'd8192) >> 14);
            end
            cur_pos++;
        end
        if (row_end || seq_end)
        begin
            if (cur_best != 0 && cur_best != prev_class)
            begin
                res = '{cur_best, ({1'b0, cur_best} >= cfg_charset), 1'b0, '0, 1'b0};
                expected_q.push_back(res);
                if (cfg_score && emit_count < COUNT_MAX && cur_exp_sum != 0)
                begin
                    p = (64'h1_0000_0000 + cur_exp_sum / 2) / cur_exp_sum;
                    prob_sum = prob_sum + p;
                    emit_count++;
                end
            end
            prev_class = cur_best;
            cur_pos = 0;
        end
        if (seq_end)
        begin
            p = 0;
            if (cfg_score && emit_count > 0)
                p = (prob_sum + emit_count / 2) / emit_count;
            res = '{'0, 1'b0, 1'b1, p[SCORE_W-1:0], 1'b1};
            expected_q.push_back(res);
            prev_class = '0;
            emit_count = 0;
            prob_sum = 0;
            seqs_sent++;
        end
    endtask

    task automatic send_logit(input logic signed [15:0] logit, input logic row_end,
                              input logic seq_end);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.logit   <= logit;
        in_ch.row_end <= row_end;
        in_ch.seq_end <= seq_end;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        decode_logit(logit, row_end, seq_end);
        items_sent++;
    endtask

    task automatic send_row(input logic seq_end);
        int i;
        for (i = 0; i < row_buf.size(); i++)
            send_logit(row_buf[i], i == row_buf.size() - 1, seq_end && i == row_buf.size() - 1);
        row_buf.delete();
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SCALE:   cfg_scale = $signed(value[4:0]);
            REG_CHARSET: cfg_charset = value[13:0];
            REG_SCORE:   cfg_score = value[0];
            default:     ;
        endcase
    endtask

    task automatic configure(input int scale, input int charset, input logic score);
        apb_write(REG_SCALE, scale);
        apb_write(REG_CHARSET, charset);
        apb_write(REG_SCORE, 32'(score));
    endtask

    task automatic random_row(input int len, input logic wide);
        int base;
        int i;
        base = $urandom_range(400) - 200;
        for (i = 0; i < len; i++)
        begin
            if (wide)
                row_buf.push_back(16'($urandom));
            else
                row_buf.push_back(16'(base + $urandom_range(60)));
        end
    endtask

    task automatic test_directed();
        // Classic decode with a repeat, a blank and a tie that keeps the first maximum.
        row_buf = '{-16'sd5, 16'sd10, 16'sd3};
        send_row(1'b0);
        row_buf = '{16'sd0, 16'sd12, 16'sd2};
        send_row(1'b0);
        row_buf = '{16'sd40, 16'sd1, 16'sd40};
        send_row(1'b0);
        row_buf = '{16'sd0, 16'sd7, 16'sd7, 16'sd6};
        send_row(1'b0);
        row_buf = '{-16'sd32768, 16'sd32767};
        send_row(1'b1);
        // A sequence with nothing emitted.
        row_buf = '{16'sd9};
        send_row(1'b1);
        // The sequence end ends the row without a row end mark.
        send_logit(16'sd1, 1'b0, 1'b0);
        send_logit(16'sd20, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_config_extremes();
        configure(32'h10, 0, 1'b1);
        row_buf = '{16'sd0, 16'sd1, 16'sd0};
        send_row(1'b0);
        row_buf = '{16'sd3, 16'sd1, 16'sd4};
        send_row(1'b1);
        drain();
        configure(32'h0F, 3, 1'b0);
        row_buf = '{16'sd0, 16'sd0, 16'sd0, 16'sd1};
        send_row(1'b0);
        row_buf = '{16'sd0, 16'sd2};
        send_row(1'b1);
        drain();
        configure(-15, 8191, 1'b1);
        row_buf = '{16'sd100, 16'sd300, 16'sd200};
        send_row(1'b1);
        drain();
        configure(0, 8192, 1'b1);
        row_buf = '{-16'sd3, 16'sd2, 16'sd1};
        send_row(1'b1);
        drain();
    endtask

    task automatic test_long_row();
        int i;
        configure(0, 100, 1'b1);
        send_logit(16'sd32766, 1'b0, 1'b0);
        for (i = 1; i < MAX_CLASSES - 1; i++)
            send_logit(-16'sd32768, 1'b0, 1'b0);
        send_logit(16'sd32767, 1'b0, 1'b0);
        send_logit(16'sd32767, 1'b0, 1'b0);
        send_logit(16'sd32767, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_count_saturation();
        int i;
        configure(0, 8192, 1'b1);
        for (i = 0; i < COUNT_MAX + 4; i++)
        begin
            row_buf = '{-16'sd32768, 16'sd32767};
            send_row(1'b0);
            row_buf = '{16'sd0};
            send_row(1'b0);
        end
        row_buf = '{16'sd5, 16'sd9};
        send_row(1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        int i;
        configure(-4, 8192, 1'b1);
        hold_cycles = 4000;
        for (i = 0; i < 12; i++)
        begin
            row_buf = '{-16'sd500, 16'sd500};
            send_row(1'b0);
            row_buf = '{16'sd1};
            send_row(i == 11);
        end
        drain();
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        int   start;
        int   rows;
        int   len;
        logic broken;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        configure($urandom_range(10) - 10, $urandom_range(8192), $urandom_range(9) != 0);
        start = items_sent;
        while (items_sent - start < count)
        begin
            rows = $urandom_range(1, 8);
            broken = ($urandom_range(9) == 0);
            repeat (rows)
            begin
                len = ($urandom_range(15) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
                random_row(len, $urandom_range(3) == 0);
                send_row(1'b0);
            end
            if (broken)
                send_logit(16'($urandom), 1'b0, 1'b1);
            else
            begin
                random_row($urandom_range(1, 3), 1'b0);
                send_row(1'b1);
            end
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        seqs_sent = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_scale = -7;
        cfg_charset = CHARSET_RESET;
        cfg_score = 1'b1;
        cur_max = 0;
        cur_best = '0;
        cur_pos = 0;
        cur_exp_sum = 0;
        prev_class = '0;
        emit_count = 0;
        prob_sum = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.logit = '0;
        in_ch.row_end = 1'b0;
        in_ch.seq_end = 1'b0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_long_row();
        test_count_saturation();
        test_backpressure();
        test_random(0, 0, 290);
        test_random(69, 0, 290);
        test_random(0, 69, 290);
        test_random(20, 20, 290);

        $display("Sent %0d logits in %0d sequences and checked %0d results.",
                 items_sent, seqs_sent, results_seen);
        $display("%s %s", "Covered extreme scales and charsets, an overlong row, count saturation,",
                 "scoring off, output hold-off and random idling.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
